FILE: hw/rtl/bcdfe_pkg.sv
// ----------------------------------------------------------------------------
// bcdfe_pkg
// Shared types, cursor slot codes and field edit rules for the BCD clock
// field editor.
// ----------------------------------------------------------------------------
package bcdfe_pkg;

  // Key operations carried by each request
  typedef enum logic [1:0] {
    OP_MOVE_RIGHT = 2'd0,
    OP_INCREMENT  = 2'd1,
    OP_DECREMENT  = 2'd2,
    OP_START_EDIT = 2'd3
  } op_e;

  typedef logic [3:0] slot_t;
  typedef logic [2:0] reg_addr_t;
  typedef logic [7:0] bcd_t;

  // Cursor slots, left to right across the display
  localparam slot_t SLOT_YEAR_TENS   = 4'd0;
  localparam slot_t SLOT_YEAR_UNITS  = 4'd1;
  localparam slot_t SLOT_MONTH_TENS  = 4'd2;
  localparam slot_t SLOT_MONTH_UNITS = 4'd3;
  localparam slot_t SLOT_DATE_TENS   = 4'd4;
  localparam slot_t SLOT_DATE_UNITS  = 4'd5;
  localparam slot_t SLOT_WEEKDAY     = 4'd6;
  localparam slot_t SLOT_AM_PM       = 4'd7;
  localparam slot_t SLOT_HOUR_TENS   = 4'd8;
  localparam slot_t SLOT_HOUR_UNITS  = 4'd9;
  localparam slot_t SLOT_MIN_TENS    = 4'd10;
  localparam slot_t SLOT_MIN_UNITS   = 4'd11;
  localparam slot_t SLOT_SEC_TENS    = 4'd12;
  localparam slot_t SLOT_SEC_UNITS   = 4'd13;

  // Clock register addresses
  localparam reg_addr_t REG_SECONDS = 3'd0;
  localparam reg_addr_t REG_MINUTES = 3'd1;
  localparam reg_addr_t REG_HOUR    = 3'd2;
  localparam reg_addr_t REG_WEEKDAY = 3'd3;
  localparam reg_addr_t REG_DATE    = 3'd4;
  localparam reg_addr_t REG_MONTH   = 3'd5;
  localparam reg_addr_t REG_YEAR    = 3'd6;

  // Field limits and masks
  localparam bcd_t YEAR_TENS_MAX  = 8'h90;
  localparam bcd_t MONTH_MAX      = 8'h12;
  localparam bcd_t DATE_MAX       = 8'h31;
  localparam bcd_t SEXA_TENS_MAX  = 8'h50;
  localparam bcd_t WEEKDAY_MAX    = 8'h07;
  localparam bcd_t HOUR_MODE_MASK = 8'h60;
  localparam bcd_t HOUR_UPPER     = 8'hE0;
  localparam bcd_t TENS_MASK      = 8'hF0;
  localparam bcd_t UNITS_MASK     = 8'h0F;
  localparam bcd_t HOUR_VAL_MASK  = 8'h1F;
  localparam bcd_t TENS_STEP      = 8'h10;
  localparam bcd_t PM_BIT         = 8'h20;

  // Register that holds the field under a cursor slot
  function automatic reg_addr_t slot_to_reg(input slot_t slot);
    reg_addr_t r;
    unique case (slot)
      SLOT_YEAR_TENS, SLOT_YEAR_UNITS:                      r = REG_YEAR;
      SLOT_MONTH_TENS, SLOT_MONTH_UNITS:                    r = REG_MONTH;
      SLOT_DATE_TENS, SLOT_DATE_UNITS:                      r = REG_DATE;
      SLOT_WEEKDAY:                                         r = REG_WEEKDAY;
      SLOT_AM_PM, SLOT_HOUR_TENS, SLOT_HOUR_UNITS:          r = REG_HOUR;
      SLOT_MIN_TENS, SLOT_MIN_UNITS:                        r = REG_MINUTES;
      default:                                              r = REG_SECONDS;
    endcase
    return r;
  endfunction

  // Tens digit of a 0..59 field, wrapping between 5 and 0
  function automatic bcd_t tens59(input bcd_t v, input logic up);
    bcd_t t;
    if (up) begin
      t = ((v & TENS_MASK) < SEXA_TENS_MAX) ? v + TENS_STEP : (v & UNITS_MASK);
    end else begin
      t = ((v & TENS_MASK) >= TENS_STEP) ? v - TENS_STEP : v + SEXA_TENS_MAX;
    end
    return t;
  endfunction

  // Units digit 0..9, wrapping
  function automatic bcd_t units9(input bcd_t v, input logic up);
    bcd_t t;
    if (up) begin
      t = ((v & UNITS_MASK) < 8'h09) ? v + 8'h01 : (v & TENS_MASK);
    end else begin
      t = ((v & UNITS_MASK) >= 8'h01) ? v - 8'h01 : v + 8'h09;
    end
    return t;
  endfunction

  // Apply the clamp and wrap rules of the field under the cursor
  function automatic bcd_t edit_field(input slot_t slot, input bcd_t v, input logic up);
    bcd_t t;
    t = v;
    case (slot) inside
      SLOT_YEAR_TENS: begin
        if (up) begin
          t = ((v & TENS_MASK) < YEAR_TENS_MAX) ? v + TENS_STEP : (v & UNITS_MASK);
        end else begin
          t = ((v & TENS_MASK) >= TENS_STEP) ? v - TENS_STEP : v + YEAR_TENS_MAX;
        end
      end
      SLOT_YEAR_UNITS, SLOT_MIN_UNITS, SLOT_SEC_UNITS: begin
        t = units9(v, up);
      end
      SLOT_MONTH_TENS: begin
        t = v ^ TENS_STEP;
        if (t == 8'h00) t = 8'h01;
        if (t > MONTH_MAX) t = MONTH_MAX;
      end
      SLOT_MONTH_UNITS: begin
        if (up) begin
          if ((v & UNITS_MASK) < 8'h09) begin
            t = v + 8'h01;
            if (t > MONTH_MAX) t = t & TENS_MASK;
          end else begin
            t = v & TENS_MASK;
            if (t == 8'h00) t = 8'h01;
          end
        end else begin
          if ((v & UNITS_MASK) >= 8'h01) begin
            t = v - 8'h01;
            if (t == 8'h00) t = 8'h09;
          end else begin
            t = v + 8'h09;
            if (t > MONTH_MAX) t = MONTH_MAX;
          end
        end
      end
      SLOT_DATE_TENS: begin
        if (up) begin
          if ((v & TENS_MASK) < 8'h30) begin
            t = v + TENS_STEP;
            if (t > DATE_MAX) t = DATE_MAX;
          end else begin
            t = v & UNITS_MASK;
            if (t == 8'h00) t = 8'h01;
          end
        end else begin
          if ((v & TENS_MASK) >= TENS_STEP) begin
            t = v - TENS_STEP;
            if (t == 8'h00) t = 8'h01;
          end else begin
            t = v + 8'h30;
            if (t > DATE_MAX) t = DATE_MAX;
          end
        end
      end
      SLOT_DATE_UNITS: begin
        if (up) begin
          if ((v & UNITS_MASK) < 8'h09) begin
            t = v + 8'h01;
            if (t > DATE_MAX) t = t & TENS_MASK;
          end else begin
            t = v & TENS_MASK;
            if (t == 8'h00) t = 8'h01;
          end
        end else begin
          if ((v & UNITS_MASK) >= 8'h01) begin
            t = v - 8'h01;
            if (t == 8'h00) t = 8'h09;
          end else begin
            t = v + 8'h09;
            if (t > DATE_MAX) t = DATE_MAX;
          end
        end
      end
      SLOT_WEEKDAY: begin
        if (up) begin
          t = (v < WEEKDAY_MAX) ? v + 8'h01 : 8'h01;
        end else begin
          t = (v > 8'h01) ? v - 8'h01 : WEEKDAY_MAX;
        end
      end
      SLOT_AM_PM: begin
        t = v ^ PM_BIT;
      end
      SLOT_HOUR_TENS: begin
        t = v ^ TENS_STEP;
        if ((t & HOUR_VAL_MASK) == 8'h00) t = t + 8'h01;
        if ((t & HOUR_VAL_MASK) > MONTH_MAX) t = (t & HOUR_MODE_MASK) + MONTH_MAX;
      end
      SLOT_HOUR_UNITS: begin
        if (up) begin
          if ((v & UNITS_MASK) < 8'h09) begin
            t = v + 8'h01;
            if ((t & HOUR_VAL_MASK) > MONTH_MAX) t = t & TENS_MASK;
          end else begin
            t = v & TENS_MASK;
            if ((t & HOUR_VAL_MASK) == 8'h00) t = t + 8'h01;
          end
        end else begin
          if ((v & UNITS_MASK) >= 8'h01) begin
            t = v - 8'h01;
            if ((t & HOUR_VAL_MASK) == 8'h00) t = (t & HOUR_UPPER) + 8'h09;
          end else begin
            t = v + 8'h09;
            if ((t & HOUR_VAL_MASK) > MONTH_MAX) t = (t & HOUR_UPPER) + MONTH_MAX;
          end
        end
      end
      SLOT_MIN_TENS, SLOT_SEC_TENS: begin
        t = tens59(v, up);
      end
      default: begin
        t = 8'h00;
      end
    endcase
    return t;
  endfunction

endpackage

FILE: hw/rtl/bcd_clock_field_editor.sv
// ----------------------------------------------------------------------------
// bcd_clock_field_editor
// Key-driven cursor and digit editor for the time and date registers of a
// BCD real-time clock.
// ----------------------------------------------------------------------------
// Takes one key request per cycle while not stalled and returns one result
// per request. A request is captured in an input register, then the cursor
// update and the field edit are worked out in one pass and stored in the
// result register, from which each result is offered. The cursor register
// is updated in that same pass, so requests may follow each other in every
// cycle. The cursor starts on the AM/PM position after reset.
// A stall on the result side holds the result register and then the input
// register; requests keep flowing as long as the result register drains.
module bcd_clock_field_editor
  import bcdfe_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [1:0] operation_i,
  input  logic [7:0] current_value_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] new_value_o,
  output logic       write_enable_o,
  output logic [2:0] register_address_o,
  output logic [3:0] cursor_position_o
);

  logic      in_valid_q, in_valid_d;
  op_e       op_q;
  bcd_t      value_q;
  logic      out_valid_q, out_valid_d;
  bcd_t      new_value_q, new_value_d;
  logic      we_q, we_d;
  reg_addr_t addr_q, addr_d;
  slot_t     cursor_q, cursor_d;
  logic      in_accept;
  logic      res_load;

  // Handshake: the result register loads when a request is waiting and the result register is empty or being drained
  assign res_load   = in_valid_q && (!out_valid_q || !out_stall_i);
  assign in_stall_o = in_valid_q && !res_load;
  assign in_accept  = in_valid_i && !in_stall_o;

  assign in_valid_d  = in_accept ? 1'b1 : (res_load ? 1'b0 : in_valid_q);
  assign out_valid_d = res_load || (out_valid_q && out_stall_i);

  // Advance the cursor and edit the field under it
  always_comb begin
    cursor_d    = cursor_q;
    new_value_d = 8'h00;
    we_d        = 1'b0;
    unique case (op_q)
      OP_MOVE_RIGHT: begin
        cursor_d = (cursor_q >= SLOT_SEC_UNITS) ? SLOT_YEAR_TENS : cursor_q + 4'd1;
      end
      OP_START_EDIT: begin
        cursor_d = SLOT_AM_PM;
      end
      OP_INCREMENT, OP_DECREMENT: begin
        if (cursor_q <= SLOT_SEC_UNITS) begin
          new_value_d = edit_field(cursor_q, value_q, op_q == OP_INCREMENT);
          we_d        = 1'b1;
        end
      end
      default: begin
        cursor_d = cursor_q;
      end
    endcase
    addr_d = slot_to_reg(cursor_d);
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cursor_q    <= SLOT_AM_PM;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
      if (res_load) begin
        cursor_q <= cursor_d;
      end
    end
  end

  // Capture the request
  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      op_q    <= op_e'(operation_i);
      value_q <= current_value_i;
    end
  end

  // Hold the result until it is taken
  always_ff @(posedge clk_i) begin
    if (res_load) begin
      new_value_q <= new_value_d;
      we_q        <= we_d;
      addr_q      <= addr_d;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign new_value_o        = new_value_q;
  assign write_enable_o     = we_q;
  assign register_address_o = addr_q;
  assign cursor_position_o  = cursor_q;

`ifndef NO_ASSERTIONS
  a_cursor_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cursor_q <= SLOT_SEC_UNITS)
    else $error("cursor left the digit range");

  a_addr_matches_cursor: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (register_address_o == slot_to_reg(cursor_position_o)))
    else $error("register address does not match cursor");

  a_move_writes_nothing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !write_enable_o) |-> (new_value_o == 8'h00))
    else $error("cursor move carries a nonzero value");

  a_stall_only_when_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (in_valid_q && out_valid_q && out_stall_i))
    else $error("input stalled without a blocked result");
`endif

endmodule

FILE: sim/bcd_clock_field_editor_tb.sv
// ----------------------------------------------------------------------------
// bcd_clock_field_editor_tb
// Self-checking bench for the BCD clock field editor. Key requests go in with
// random gaps and results are drained with random stalls. A scoreboard keeps
// its own cursor, works out the edited byte for each request and compares
// every result field by field, in order.
// ----------------------------------------------------------------------------
module bcd_clock_field_editor_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import bcdfe_pkg::*;

  typedef struct packed {
    bcd_t      value;
    logic      wr;
    reg_addr_t addr;
    slot_t     slot;
  } edit_result_t;

  // Cursor tracking and field edit rules, plus the queue of awaited results
  class edit_scoreboard;
    slot_t        cursor;
    edit_result_t awaited[$];
    int unsigned  failures;

    function new();
      cursor   = SLOT_AM_PM;
      failures = 0;
    endfunction

    static function reg_addr_t register_of(slot_t s);
      reg_addr_t a;
      case (s)
        SLOT_YEAR_TENS, SLOT_YEAR_UNITS:             a = REG_YEAR;
        SLOT_MONTH_TENS, SLOT_MONTH_UNITS:           a = REG_MONTH;
        SLOT_DATE_TENS, SLOT_DATE_UNITS:             a = REG_DATE;
        SLOT_WEEKDAY:                                a = REG_WEEKDAY;
        SLOT_AM_PM, SLOT_HOUR_TENS, SLOT_HOUR_UNITS: a = REG_HOUR;
        SLOT_MIN_TENS, SLOT_MIN_UNITS:               a = REG_MINUTES;
        default:                                     a = REG_SECONDS;
      endcase
      return a;
    endfunction

    // Tens digit wrapping between zero and the top tens value
    static function bcd_t tens_wrapped(bcd_t b, bit up, bcd_t top);
      if (up) return (b[7:4] < top[7:4]) ? b + TENS_STEP : b & UNITS_MASK;
      return (b[7:4] != 4'd0) ? b - TENS_STEP : b + top;
    endfunction

    static function bcd_t units_wrapped(bcd_t b, bit up);
      if (up) return (b[3:0] < 4'd9) ? b + 8'h01 : b & TENS_MASK;
      return (b[3:0] != 4'd0) ? b - 8'h01 : b + 8'h09;
    endfunction

    // Month and date units: never zero, clamped to the field maximum
    static function bcd_t units_clamped(bcd_t b, bit up, bcd_t top);
      bcd_t r;
      if (up) begin
        if (b[3:0] < 4'd9) begin
          r = b + 8'h01;
          if (r > top) r = r & TENS_MASK;
        end else begin
          r = b & TENS_MASK;
          if (r == 8'h00) r = 8'h01;
        end
      end else begin
        if (b[3:0] != 4'd0) begin
          r = b - 8'h01;
          if (r == 8'h00) r = 8'h09;
        end else begin
          r = b + 8'h09;
          if (r > top) r = top;
        end
      end
      return r;
    endfunction

    static function bcd_t edited_byte(slot_t s, bcd_t b, bit up);
      bcd_t r;
      r = 8'h00;
      case (s)
        SLOT_YEAR_TENS: r = tens_wrapped(b, up, YEAR_TENS_MAX);
        SLOT_MIN_TENS, SLOT_SEC_TENS: r = tens_wrapped(b, up, SEXA_TENS_MAX);
        SLOT_YEAR_UNITS, SLOT_MIN_UNITS, SLOT_SEC_UNITS: r = units_wrapped(b, up);
        SLOT_MONTH_UNITS: r = units_clamped(b, up, MONTH_MAX);
        SLOT_DATE_UNITS:  r = units_clamped(b, up, DATE_MAX);
        SLOT_MONTH_TENS: begin
          r = b ^ TENS_STEP;
          if (r == 8'h00) r = 8'h01;
          if (r > MONTH_MAX) r = MONTH_MAX;
        end
        SLOT_DATE_TENS: begin
          if (up) begin
            if (b[7:4] < 4'd3) begin
              r = b + TENS_STEP;
              if (r > DATE_MAX) r = DATE_MAX;
            end else begin
              r = b & UNITS_MASK;
              if (r == 8'h00) r = 8'h01;
            end
          end else begin
            if (b[7:4] != 4'd0) begin
              r = b - TENS_STEP;
              if (r == 8'h00) r = 8'h01;
            end else begin
              r = b + 8'h30;
              if (r > DATE_MAX) r = DATE_MAX;
            end
          end
        end
        // Weekday runs 1..7 and wraps at both ends
        SLOT_WEEKDAY: begin
          if (up) r = (b < WEEKDAY_MAX) ? b + 8'h01 : 8'h01;
          else    r = (b > 8'h01) ? b - 8'h01 : WEEKDAY_MAX;
        end
        SLOT_AM_PM: r = b ^ PM_BIT;
        // Hour digits keep the 12-hour and PM bits
        SLOT_HOUR_TENS: begin
          r = b ^ TENS_STEP;
          if ((r & HOUR_VAL_MASK) == 8'h00) r = r + 8'h01;
          if ((r & HOUR_VAL_MASK) > MONTH_MAX) r = (r & HOUR_MODE_MASK) + MONTH_MAX;
        end
        SLOT_HOUR_UNITS: begin
          if (up) begin
            if (b[3:0] < 4'd9) begin
              r = b + 8'h01;
              if ((r & HOUR_VAL_MASK) > MONTH_MAX) r = r & TENS_MASK;
            end else begin
              r = b & TENS_MASK;
              if ((r & HOUR_VAL_MASK) == 8'h00) r = r + 8'h01;
            end
          end else begin
            if (b[3:0] != 4'd0) begin
              r = b - 8'h01;
              if ((r & HOUR_VAL_MASK) == 8'h00) r = (r & HOUR_UPPER) + 8'h09;
            end else begin
              r = b + 8'h09;
              if ((r & HOUR_VAL_MASK) > MONTH_MAX) r = (r & HOUR_UPPER) + MONTH_MAX;
            end
          end
        end
        default: r = 8'h00;
      endcase
      return r;
    endfunction

    // Advance the cursor for an accepted request and queue its result
    function void note_request(op_e op, bcd_t b);
      edit_result_t r;
      r.value = 8'h00;
      r.wr    = 1'b0;
      case (op)
        OP_MOVE_RIGHT: cursor = (cursor >= SLOT_SEC_UNITS) ? SLOT_YEAR_TENS : cursor + 4'd1;
        OP_START_EDIT: cursor = SLOT_AM_PM;
        default: begin
          r.value = edited_byte(cursor, b, op == OP_INCREMENT);
          r.wr    = 1'b1;
        end
      endcase
      r.addr = register_of(cursor);
      r.slot = cursor;
      awaited.push_back(r);
    endfunction

    function void compare(string field, int unsigned want, int unsigned got);
      if (want != got) begin
        $display("%0t ns: %s mismatch, expected 0x%0h, actual 0x%0h", $time, field, want, got);
        failures++;
      end
    endfunction

    function void check_result(edit_result_t got);
      edit_result_t want;
      if (awaited.size() == 0) begin
        $display("%0t ns: result with no request outstanding, expected none, actual 0x%0h",
                 $time, got);
        failures++;
        return;
      end
      want = awaited.pop_front();
      compare("new_value", want.value, got.value);
      compare("write_enable", want.wr, got.wr);
      compare("register_address", want.addr, got.addr);
      compare("cursor_position", want.slot, got.slot);
    endfunction
  endclass

  localparam int unsigned RANDOM_REQUESTS = 1050;
  localparam int unsigned PRESSURE_HOLD   = 300;

  localparam bcd_t BOUNDARY_BYTES [12] = '{8'h00, 8'h01, 8'h07, 8'h09, 8'h10, 8'h12,
                                           8'h13, 8'h31, 8'h50, 8'h59, 8'h90, 8'hFF};

  logic       clk = 1'b0;
  logic       rst_n;
  logic       in_valid;
  logic       in_stall;
  op_e        operation;
  bcd_t       current_value;
  logic       out_valid;
  logic       out_stall;
  bcd_t       new_value;
  logic       write_enable;
  reg_addr_t  register_address;
  slot_t      cursor_position;

  bit             no_idle      = 1'b0;
  bit             pressure_req = 1'b0;
  edit_scoreboard sb           = new();

  bcd_clock_field_editor u_top (
    .clk_i              (clk),
    .rst_ni             (rst_n),
    .in_valid_i         (in_valid),
    .in_stall_o         (in_stall),
    .operation_i        (operation),
    .current_value_i    (current_value),
    .out_valid_o        (out_valid),
    .out_stall_i        (out_stall),
    .new_value_o        (new_value),
    .write_enable_o     (write_enable),
    .register_address_o (register_address),
    .cursor_position_o  (cursor_position)
  );

  always #1 clk = ~clk;

  // Offer one request after a random gap and hold it until it is taken
  task automatic send_request(op_e op, bcd_t b);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid      <= 1'b1;
    operation     <= op;
    current_value <= b;
    do @(posedge clk); while (in_stall);
    sb.note_request(op, b);
  endtask

  function automatic op_e random_op();
    int unsigned pick;
    pick = $urandom_range(0, 99);
    if (pick < 30) return OP_MOVE_RIGHT;
    if (pick < 60) return OP_INCREMENT;
    if (pick < 88) return OP_DECREMENT;
    return OP_START_EDIT;
  endfunction

  // Mix of raw bytes, clean BCD, hour-style bytes and boundary values
  function automatic bcd_t random_byte();
    bcd_t b;
    case ($urandom_range(0, 3))
      0: b = 8'($urandom_range(0, 255));
      1: b = {4'($urandom_range(0, 9)), 4'($urandom_range(0, 9))};
      2: b = {1'b0, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
              1'($urandom_range(0, 1)), 4'($urandom_range(0, 9))};
      default: b = BOUNDARY_BYTES[4'($urandom_range(0, 11))];
    endcase
    return b;
  endfunction

  // Drain results, stalling at random after each one
  initial begin
    int unsigned  hold;
    edit_result_t got;
    hold = 0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_valid && !out_stall) begin
        got.value = new_value;
        got.wr    = write_enable;
        got.addr  = register_address;
        got.slot  = cursor_position;
        sb.check_result(got);
        hold = no_idle ? 0 : $urandom_range(0, 10);
      end
      // Long hold-off so that the block fills and pushes back on requests
      if (pressure_req) begin
        pressure_req = 1'b0;
        hold         = PRESSURE_HOLD;
      end
      if (hold != 0) begin
        out_stall <= 1'b1;
        hold--;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Stimulus
  initial begin
    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    operation     <= OP_MOVE_RIGHT;
    current_value <= 8'h00;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Edit the AM/PM bit straight out of reset, then restart editing
    send_request(OP_INCREMENT, 8'h00);
    send_request(OP_DECREMENT, 8'hFF);
    send_request(OP_START_EDIT, 8'h5A);
    // Hour digits with the 12-hour bit set, and the PM bit set in the first
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h72);
    send_request(OP_MOVE_RIGHT, 8'hFF);
    send_request(OP_DECREMENT, 8'h41);
    // Minutes and seconds
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h59);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_DECREMENT, 8'h50);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h99);
    // Cursor wraps from second units back to year tens
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h99);
    send_request(OP_MOVE_RIGHT, 8'h00);
    // Month, date and weekday limits
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h12);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_DECREMENT, 8'h10);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h29);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_DECREMENT, 8'h30);
    send_request(OP_MOVE_RIGHT, 8'h00);
    send_request(OP_INCREMENT, 8'h07);
    send_request(OP_DECREMENT, 8'h00);

    // Random requests, with stretches free of idling on both sides
    for (int unsigned i = 0; i < RANDOM_REQUESTS; i++) begin
      if (i % 150 == 0) no_idle = ($urandom_range(0, 2) == 0);
      if (i == 400) pressure_req = 1'b1;
      send_request(random_op(), random_byte());
    end
    in_valid <= 1'b0;

    // Drain, then allow the pipeline latency to pass
    while (sb.awaited.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
    if (sb.failures == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #600_000;
    $display("Regression FAIL");
    $finish;
  end

endmodule

FILE: filelist.f
hw/rtl/bcdfe_pkg.sv
hw/rtl/bcd_clock_field_editor.sv
sim/bcd_clock_field_editor_tb.sv
